/* hdl/rtc_bcd_to_unix_seconds_core_macros.svh */
// ----------------------------------------------------------------------------
// RTC BCD to Unix seconds: assertion macros
// Shared concurrent assertion forms used by the core's modules.
// ----------------------------------------------------------------------------
`ifndef RTC_BCD_TO_UNIX_SECONDS_CORE_MACROS_SVH
`define RTC_BCD_TO_UNIX_SECONDS_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBU_ASSERT_IMPLY(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("rbu: same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define RBU_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("rbu: next-cycle implication failed");

`endif

/* hdl/rbu_pkg.sv */
// ----------------------------------------------------------------------------
// RTC BCD to Unix seconds: package
// Types, constants and small decode functions shared by the pipeline stages.
// ----------------------------------------------------------------------------
package rbu_pkg;

    // Raw register snapshot, seconds register in the lowest byte.
    typedef struct packed {
        logic [7:0] year_reg;
        logic [7:0] month_reg;
        logic [7:0] date_reg;
        logic [7:0] weekday_reg;
        logic [7:0] hours_reg;
        logic [7:0] minutes_reg;
        logic [7:0] seconds_reg;
    } raw_regs_t;

    // One checked register field.
    typedef struct packed {
        logic       ok;
        logic [6:0] val;
    } bcd_field_t;

    // Stage 1 result: checked fields in binary.
    typedef struct packed {
        logic       ok;
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hr;
        logic [4:0] day;
        logic [3:0] mon;
        logic [6:0] yr;
    } decoded_t;

    // Stage 2 result: day-count terms and seconds within the day.
    typedef struct packed {
        logic        ok;
        logic [16:0] hms;
        logic [15:0] yr_days;
        logic [4:0]  leap_days;
        logic [8:0]  mon_days;
        logic [4:0]  day;
    } partial_t;

    // Stage 3 result: days since the epoch and seconds within the day.
    typedef struct packed {
        logic        ok;
        logic [15:0] days;
        logic [16:0] hms;
    } day_count_t;

    // Reserved-bit and value masks of each register.
    localparam logic [7:0] SEC_RSV   = 8'h80;
    localparam logic [7:0] SEC_MASK  = 8'h7F;
    localparam logic [7:0] HR_RSV    = 8'hC0;
    localparam logic [7:0] HR_MASK   = 8'h3F;
    localparam logic [7:0] WD_RSV    = 8'hF8;
    localparam logic [7:0] WD_MASK   = 8'h07;
    localparam logic [7:0] DATE_RSV  = 8'hC0;
    localparam logic [7:0] DATE_MASK = 8'h3F;
    localparam logic [7:0] MON_RSV   = 8'h60;
    localparam logic [7:0] MON_MASK  = 8'h1F;
    localparam logic [7:0] YR_RSV    = 8'h00;
    localparam logic [7:0] YR_MASK   = 8'hFF;

    // Days from 1970-01-01 to 2000-01-01, and seconds per day.
    localparam logic [15:0] DAYS_TO_2000 = 16'd10957;
    localparam logic [31:0] SECS_PER_DAY = 32'd86400;
    localparam logic [16:0] SECS_PER_HR  = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN = 17'd60;
    localparam logic [15:0] DAYS_PER_YR  = 16'd365;

    // Checks reserved bits, both BCD digits and the range; returns the value.
    function automatic bcd_field_t check_field(
        input logic [7:0] raw,
        input logic [7:0] rsv,
        input logic [7:0] vmask,
        input logic [6:0] lo,
        input logic [6:0] hi
    );
        logic [7:0] b;
        logic [3:0] tens;
        logic [3:0] ones;
        logic [6:0] v;
        bcd_field_t r;
        b    = raw & vmask;
        tens = b[7:4];
        ones = b[3:0];
        v    = 7'({3'b000, tens} << 3) + 7'({3'b000, tens} << 1) + 7'(ones);
        r.ok = ((raw & rsv) == 8'h00) && (tens <= 4'd9) && (ones <= 4'd9) &&
               (v >= lo) && (v <= hi);
        r.val = v;
        return r;
    endfunction

    // Length of a month in days.
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd2: begin
                len = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

    // Days of the year before the first of a month.
    function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
        logic [8:0] base;
        case (mon)
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + 9'((leap && (mon > 4'd2)) ? 1 : 0);
    endfunction

endpackage

/* hdl/rtc_bcd_to_unix_seconds_core.sv */
// ----------------------------------------------------------------------------
// RTC BCD to Unix seconds core
// Converts a raw BCD real-time-clock register snapshot to Unix seconds.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one snapshot of the seven timekeeping bytes
//   per transfer in s_tdata. Each transfer yields exactly one master-side
//   transfer: m_tuser[0] is the validity flag and m_tdata the seconds since
//   1970-01-01 00:00:00 (zero when the snapshot is invalid).
//   The result passes through four register stages: field decode,
//   day-in-month check and day-count terms, day sum, and the day-to-seconds
//   multiply-add. Throughput is one snapshot per cycle while m_tready is
//   high; every stage has its own valid bit and loads whenever it is empty
//   or its data moves on.
//   When the receiver holds m_tready low, the result stays on the port and
//   the stages behind it fill up; s_tready falls only once every stage
//   holds data. Nothing is dropped or repeated.
//   Reset (aresetn low at a clock edge) empties all stages; the block
//   takes transfers from the first cycle after reset.
// ----------------------------------------------------------------------------
module rtc_bcd_to_unix_seconds_core
    import rbu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Slave channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: seconds_reg, minutes_reg, hours_reg, weekday_reg,
    // date_reg, month_reg, year_reg (8 bits each).
    input  logic [55:0] s_tdata,
    // Master channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: unix_seconds (32 bits).
    output logic [31:0] m_tdata,
    // m_tuser from bit 0: time_valid (1 bit).
    output logic [0:0]  m_tuser
);

    raw_regs_t  raw;
    logic       dec_valid;
    logic       dec_ready;
    decoded_t   dec_data;
    logic       day_valid;
    logic       day_ready;
    day_count_t day_data;
    logic       time_valid;

    assign raw = raw_regs_t'(s_tdata);

    // Stage 1: field checks and BCD decode.
    rbu_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (raw),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    // Stages 2 and 3: calendar check and day count.
    rbu_days u_days (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (day_valid),
        .out_ready (day_ready),
        .out_data  (day_data)
    );

    // Stage 4: seconds and the output register.
    rbu_scale u_scale (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (day_valid),
        .in_ready     (day_ready),
        .in_data      (day_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .time_valid   (time_valid),
        .unix_seconds (m_tdata)
    );

    assign m_tuser[0] = time_valid;

`include "rtc_bcd_to_unix_seconds_core_macros.svh"

    // An invalid snapshot always reports zero seconds.
    `RBU_ASSERT_IMPLY(a_invalid_zero, aclk, aresetn, m_tvalid && !m_tuser[0],
        m_tdata == 32'd0)

    // A valid result never passes the end of 2099.
    `RBU_ASSERT_IMPLY(a_max_seconds, aclk, aresetn, m_tvalid && m_tuser[0],
        m_tdata <= 32'd4102444799)

    // Input back-pressure only comes from a stalled output.
    `RBU_ASSERT_IMPLY(a_ready_cause, aclk, aresetn, !s_tready,
        m_tvalid && !m_tready)

    // A stalled result stays on the port unchanged.
    `RBU_ASSERT_NEXT(a_hold_stable, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

/* hdl/rbu_decode.sv */
// ----------------------------------------------------------------------------
// RTC BCD to Unix seconds: field decode stage
// Checks every register byte and converts the BCD fields to binary.
// ----------------------------------------------------------------------------
module rbu_decode
    import rbu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  raw_regs_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output decoded_t  out_data
);

    logic       valid_reg;
    decoded_t   data_reg;
    decoded_t   data_next;
    bcd_field_t f_sec;
    bcd_field_t f_min;
    bcd_field_t f_hr;
    bcd_field_t f_wd;
    bcd_field_t f_day;
    bcd_field_t f_mon;
    bcd_field_t f_yr;

    // Per-register checks; the weekday only takes part in validity.
    always_comb begin
        f_sec = check_field(in_data.seconds_reg, SEC_RSV, SEC_MASK, 7'd0, 7'd59);
        f_min = check_field(in_data.minutes_reg, SEC_RSV, SEC_MASK, 7'd0, 7'd59);
        f_hr  = check_field(in_data.hours_reg, HR_RSV, HR_MASK, 7'd0, 7'd23);
        f_wd  = check_field(in_data.weekday_reg, WD_RSV, WD_MASK, 7'd1, 7'd7);
        f_day = check_field(in_data.date_reg, DATE_RSV, DATE_MASK, 7'd1, 7'd31);
        f_mon = check_field(in_data.month_reg, MON_RSV, MON_MASK, 7'd1, 7'd12);
        f_yr  = check_field(in_data.year_reg, YR_RSV, YR_MASK, 7'd0, 7'd99);
        data_next.ok  = f_sec.ok && f_min.ok && f_hr.ok && f_wd.ok &&
                        f_day.ok && f_mon.ok && f_yr.ok;
        data_next.sec = f_sec.val[5:0];
        data_next.min = f_min.val[5:0];
        data_next.hr  = f_hr.val[4:0];
        data_next.day = f_day.val[4:0];
        data_next.mon = f_mon.val[3:0];
        data_next.yr  = f_yr.val;
    end

    // The stage takes a new transfer when it is empty or its result moves on.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

`include "rtc_bcd_to_unix_seconds_core_macros.svh"

    // A valid decode has its date fields inside their calendar ranges.
    `RBU_ASSERT_IMPLY(a_dec_range, aclk, aresetn, valid_reg && data_reg.ok,
        (data_reg.mon >= 4'd1) && (data_reg.mon <= 4'd12) && (data_reg.day >= 5'd1))

endmodule

/* hdl/rbu_days.sv */
// ----------------------------------------------------------------------------
// RTC BCD to Unix seconds: day count stages
// Checks the day against its month and sums days since 1970 over two stages.
// ----------------------------------------------------------------------------
module rbu_days
    import rbu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  decoded_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output day_count_t out_data
);

    logic       s2_valid_reg;
    logic       s2_ready;
    partial_t   s2_reg;
    partial_t   s2_next;
    logic       s3_valid_reg;
    logic       s3_ready;
    day_count_t s3_reg;
    day_count_t s3_next;
    logic       leap;

    // Stage 2: leap year, day-in-month check and the day-count terms.
    // Years 2000 to 2099 are leap exactly when divisible by four.
    always_comb begin
        leap              = (in_data.yr[1:0] == 2'b00);
        s2_next.ok        = in_data.ok && (in_data.day <= month_len(in_data.mon, leap));
        s2_next.hms       = 17'(in_data.hr) * SECS_PER_HR + 17'(in_data.min) * SECS_PER_MIN
                          + 17'(in_data.sec);
        s2_next.yr_days   = 16'(in_data.yr) * DAYS_PER_YR;
        s2_next.leap_days = 5'((8'(in_data.yr) + 8'd3) >> 2);
        s2_next.mon_days  = month_start(in_data.mon, leap);
        s2_next.day       = in_data.day;
    end

    // Stage 3: days since the epoch.
    always_comb begin
        s3_next.ok   = s2_reg.ok;
        s3_next.days = DAYS_TO_2000 + s2_reg.yr_days + 16'(s2_reg.leap_days)
                     + 16'(s2_reg.mon_days) + 16'(s2_reg.day) - 16'd1;
        s3_next.hms  = s2_reg.hms;
    end

    // Each stage advances when empty or when the stage after it takes its data.
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign in_ready  = s2_ready;
    assign out_valid = s3_valid_reg;
    assign out_data  = s3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s2_ready) begin
                s2_valid_reg <= in_valid;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && in_valid) begin
            s2_reg <= s2_next;
        end
        if (s3_ready && s2_valid_reg) begin
            s3_reg <= s3_next;
        end
    end

endmodule

/* hdl/rbu_scale.sv */
// ----------------------------------------------------------------------------
// RTC BCD to Unix seconds: output stage
// Scales days to seconds, adds the time of day and zeroes invalid results.
// ----------------------------------------------------------------------------
module rbu_scale
    import rbu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  day_count_t  in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        time_valid,
    output logic [31:0] unix_seconds
);

    logic        valid_reg;
    logic        ok_reg;
    logic [31:0] secs_reg;
    logic [31:0] secs_next;

    // One constant multiply and one add; the result is at most 4102444799.
    assign secs_next = in_data.ok ? (32'(in_data.days) * SECS_PER_DAY + 32'(in_data.hms))
                                  : 32'd0;

    assign in_ready     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign time_valid   = ok_reg;
    assign unix_seconds = secs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ok_reg   <= in_data.ok;
            secs_reg <= secs_next;
        end
    end

endmodule
